// File: hw/rtl/vps_pkg.sv
`timescale 1ns / 1ps
package vps_pkg;

    localparam int OP_BITS  = 3;
    localparam int TAG_BITS = 16;
    localparam int RAD_BITS = 24;
    localparam int CNT_BITS = 5;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_READ    = 3'd1,
        OP_NEAREST = 3'd2,
        OP_KNN     = 3'd3,
        OP_PRUNE   = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_POINT    = 3'd0,
        ST_NONE     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_PRUNED   = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic load_query;   // capture query fields
        logic ins_write;    // write inserted point at fill count
        logic scan_clear;   // reset scan index and best
        logic dist_issue;   // compute distance for scan index (stage 1)
        logic dist_eval;    // evaluate stage 2 result
        logic pass_clear;   // start a new selection pass
        logic mark_best;    // mark best as taken, load output from best
        logic load_out_idx; // load output from scan index
        logic prune_wr;     // compact keep point
        logic prune_done;   // commit prune count
    } vps_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;     // scan index reached fill count
        logic has_best;
        logic room;         // insert allowed
    } vps_sts_t;

endpackage

// File: hw/rtl/vps_if.sv
`timescale 1ns / 1ps
interface vps_in_if #(parameter int COORD_BITS = 24);
    logic valid;
    logic ready;
    logic [2:0] opcode;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [15:0] point_tag;
    logic [23:0] radius;
    logic [4:0] count_limit;
    modport source (output valid, opcode, point_x, point_y, point_z, point_tag,
                    radius, count_limit, input ready);
    modport sink (input valid, opcode, point_x, point_y, point_z, point_tag,
                  radius, count_limit, output ready);
endinterface

interface vps_out_if #(parameter int COORD_BITS = 24);
    logic valid;
    logic ready;
    logic [2:0] status;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic signed [COORD_BITS-1:0] out_z;
    logic [15:0] out_tag;
    logic [4:0] stored_count;
    logic last;
    modport source (output valid, status, out_x, out_y, out_z, out_tag,
                    stored_count, last, input ready);
    modport sink (input valid, status, out_x, out_y, out_z, out_tag,
                  stored_count, last, output ready);
endinterface

// File: hw/rtl/vps_datapath.sv
`timescale 1ns / 1ps
module vps_datapath #(
    parameter int CAPACITY   = 16,
    parameter int COORD_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [4:0] capacity_limit,
    input  logic [2:0] opcode,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic [15:0] point_tag,
    input  logic [23:0] radius,
    input  vps_pkg::vps_cmd_t cmd,
    output vps_pkg::vps_sts_t sts,
    output logic dist_in_rad,
    output logic signed [COORD_BITS-1:0] res_x,
    output logic signed [COORD_BITS-1:0] res_y,
    output logic signed [COORD_BITS-1:0] res_z,
    output logic [15:0] res_tag,
    output logic [4:0] fill_count
);
    localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SQ_BITS  = 2 * COORD_BITS;
    localparam int D_BITS   = 64;

    logic signed [COORD_BITS-1:0] mem_x [CAPACITY];
    logic signed [COORD_BITS-1:0] mem_y [CAPACITY];
    logic signed [COORD_BITS-1:0] mem_z [CAPACITY];
    logic [15:0] mem_tag [CAPACITY];

    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] scan_reg;
    logic [CNT_W-1:0] wr_reg;
    logic [CAPACITY-1:0] taken_reg;
    logic signed [COORD_BITS-1:0] qx_reg, qy_reg, qz_reg;
    logic [47:0] rsq_reg;
    logic [D_BITS-1:0] best_d_reg;
    logic [IDX_BITS-1:0] best_i_reg;
    logic best_v_reg;
    logic [IDX_BITS-1:0] s1_idx_reg;
    logic signed [COORD_BITS-1:0] s1_px_reg, s1_py_reg, s1_pz_reg;
    logic [15:0] s1_pt_reg;
    logic [SQ_BITS-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [IDX_BITS-1:0] rd_sel;

    logic [CNT_W-1:0] lim;
    logic [COORD_BITS:0] dx, dy, dz, ax, ay, az;
    logic [D_BITS+1:0] dsum;
    logic [D_BITS-1:0] dsat;
    logic cand;

    assign lim = (capacity_limit == 5'd0 || 32'(capacity_limit) > CAPACITY)
                 ? CNT_W'(CAPACITY) : CNT_W'(capacity_limit);

    assign rd_sel = scan_reg[IDX_BITS-1:0];

    assign dx = {s1_px_reg[COORD_BITS-1], s1_px_reg} - {qx_reg[COORD_BITS-1], qx_reg};
    assign dy = {s1_py_reg[COORD_BITS-1], s1_py_reg} - {qy_reg[COORD_BITS-1], qy_reg};
    assign dz = {s1_pz_reg[COORD_BITS-1], s1_pz_reg} - {qz_reg[COORD_BITS-1], qz_reg};
    assign ax = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    assign ay = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    assign az = dz[COORD_BITS] ? (~dz + 1'b1) : dz;

    assign dsum = (D_BITS+2)'(sqx_reg) + (D_BITS+2)'(sqy_reg) + (D_BITS+2)'(sqz_reg);
    assign dsat = (dsum[D_BITS+1:D_BITS] != 2'b00) ? {D_BITS{1'b1}} : dsum[D_BITS-1:0];
    assign dist_in_rad = dsat <= D_BITS'(rsq_reg);
    assign cand = (opcode == vps_pkg::OP_NEAREST) ? 1'b1
                : (dist_in_rad && !taken_reg[s1_idx_reg]);

    always_ff @(posedge clk)
    begin
        if (cmd.ins_write) begin
            mem_x[fill_reg[IDX_BITS-1:0]]   <= point_x;
            mem_y[fill_reg[IDX_BITS-1:0]]   <= point_y;
            mem_z[fill_reg[IDX_BITS-1:0]]   <= point_z;
            mem_tag[fill_reg[IDX_BITS-1:0]] <= point_tag;
        end else if (cmd.prune_wr) begin
            mem_x[wr_reg[IDX_BITS-1:0]]   <= s1_px_reg;
            mem_y[wr_reg[IDX_BITS-1:0]]   <= s1_py_reg;
            mem_z[wr_reg[IDX_BITS-1:0]]   <= s1_pz_reg;
            mem_tag[wr_reg[IDX_BITS-1:0]] <= s1_pt_reg;
        end
        if (cmd.dist_issue) begin
            s1_idx_reg <= rd_sel;
            s1_px_reg  <= mem_x[rd_sel];
            s1_py_reg  <= mem_y[rd_sel];
            s1_pz_reg  <= mem_z[rd_sel];
            s1_pt_reg  <= mem_tag[rd_sel];
        end
        sqx_reg <= ax[COORD_BITS-1:0] * ax[COORD_BITS-1:0] + SQ_BITS'(0);
        sqy_reg <= ay[COORD_BITS-1:0] * ay[COORD_BITS-1:0] + SQ_BITS'(0);
        sqz_reg <= az[COORD_BITS-1:0] * az[COORD_BITS-1:0] + SQ_BITS'(0);
        if (cmd.load_query) begin
            qx_reg   <= point_x;
            qy_reg   <= point_y;
            qz_reg   <= point_z;
            rsq_reg  <= radius * radius + 48'd0;
        end
        if (cmd.mark_best) begin
            res_x   <= mem_x[best_i_reg];
            res_y   <= mem_y[best_i_reg];
            res_z   <= mem_z[best_i_reg];
            res_tag <= mem_tag[best_i_reg];
        end else if (cmd.load_out_idx) begin
            res_x   <= mem_x[rd_sel];
            res_y   <= mem_y[rd_sel];
            res_z   <= mem_z[rd_sel];
            res_tag <= mem_tag[rd_sel];
        end
        if (cmd.dist_eval && cand && (!best_v_reg || dsat < best_d_reg)) begin
            best_d_reg <= dsat;
            best_i_reg <= s1_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fill_reg   <= '0;
            scan_reg   <= '0;
            wr_reg     <= '0;
            taken_reg  <= '0;
            best_v_reg <= 1'b0;
        end else begin
            if (cmd.ins_write)
                fill_reg <= fill_reg + 1'b1;
            if (cmd.prune_done)
                fill_reg <= wr_reg;
            if (cmd.scan_clear) begin
                scan_reg   <= '0;
                wr_reg     <= '0;
                best_v_reg <= 1'b0;
                taken_reg  <= '0;
            end else begin
                if (cmd.pass_clear) begin
                    scan_reg   <= '0;
                    best_v_reg <= 1'b0;
                end else if (cmd.dist_issue || cmd.load_out_idx) begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (cmd.prune_wr)
                    wr_reg <= wr_reg + 1'b1;
                if (cmd.dist_eval && cand)
                    best_v_reg <= 1'b1;
                if (cmd.mark_best)
                    taken_reg[best_i_reg] <= 1'b1;
            end
        end
    end

    assign sts.scan_end = (scan_reg >= fill_reg);
    assign sts.has_best = best_v_reg;
    assign sts.room     = (fill_reg < lim);
    assign fill_count   = 5'(fill_reg);
endmodule

// File: hw/rtl/vps_ctrl.sv
`timescale 1ns / 1ps
module vps_ctrl (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic [2:0] opcode,
    input  logic [4:0] count_limit,
    input  logic [2:0] op_q,
    input  logic dist_in_rad,
    input  vps_pkg::vps_sts_t sts,
    output vps_pkg::vps_cmd_t cmd,
    output logic load_op,
    output logic out_valid,
    input  logic out_ready,
    output logic [2:0] out_status,
    output logic out_point,
    output logic out_last
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_D1   = 7'b0000100,
        S_D2   = 7'b0001000,
        S_PICK = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_LOAD = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0] want_reg, nout_reg, match_reg;
    logic ov_reg, last_reg, pt_reg, first_reg;
    logic [2:0] st_reg;
    logic acc, ofree, op_scan, knn_last, read_none;

    assign ofree    = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && ofree;
    assign acc      = in_valid && in_ready;
    assign load_op  = acc;
    assign out_valid = ov_reg;
    assign out_status = st_reg;
    assign out_point = pt_reg;
    assign out_last = last_reg;

    assign op_scan = (opcode == vps_pkg::OP_READ || opcode == vps_pkg::OP_NEAREST
                      || opcode == vps_pkg::OP_KNN || opcode == vps_pkg::OP_PRUNE);
    // final k-nearest item: limit reached or every match returned
    assign knn_last = ((nout_reg + 5'd1) == want_reg) || ((nout_reg + 5'd1) == match_reg);
    assign read_none = (state_reg == S_SCAN) && (op_q == vps_pkg::OP_READ) && sts.scan_end
                       && (nout_reg == 5'd0) && ofree;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc) begin
                    cmd.load_query = 1'b1;
                    cmd.scan_clear = 1'b1;
                    if (opcode == vps_pkg::OP_INSERT)
                        cmd.ins_write = sts.room;
                    else if (op_scan)
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (op_q == vps_pkg::OP_READ) begin
                    if (sts.scan_end) begin
                        if (nout_reg != 5'd0 || ofree)
                            state_next = S_IDLE;
                    end else if (ofree) begin
                        cmd.load_out_idx = 1'b1;
                        state_next = S_LOAD;
                    end
                end else if (sts.scan_end) begin
                    state_next = S_PICK;
                end else begin
                    cmd.dist_issue = 1'b1;
                    state_next = S_D1;
                end
            end
            S_LOAD:
            begin
                if (op_q == vps_pkg::OP_NEAREST) begin
                    state_next = S_IDLE;
                end else if (op_q == vps_pkg::OP_KNN) begin
                    if (knn_last) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.pass_clear = 1'b1;
                        state_next = S_SCAN;
                    end
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_D1:
                state_next = S_D2;
            S_D2:
            begin
                if (op_q == vps_pkg::OP_PRUNE)
                    cmd.prune_wr = dist_in_rad;
                else
                    cmd.dist_eval = 1'b1;
                state_next = S_SCAN;
            end
            S_PICK:
            begin
                if (ofree) begin
                    if (op_q == vps_pkg::OP_PRUNE) begin
                        cmd.prune_done = 1'b1;
                        state_next = S_OUT;
                    end else if (sts.has_best && (op_q == vps_pkg::OP_NEAREST
                                 || nout_reg < want_reg)) begin
                        cmd.mark_best = 1'b1;
                        state_next = S_LOAD;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            want_reg  <= '0;
            nout_reg  <= '0;
            match_reg <= '0;
            first_reg <= 1'b0;
            ov_reg    <= 1'b0;
            last_reg  <= 1'b0;
            pt_reg    <= 1'b0;
            st_reg    <= vps_pkg::ST_NONE;
        end else begin
            state_reg <= state_next;
            if (acc) begin
                nout_reg  <= '0;
                match_reg <= '0;
                first_reg <= 1'b1;
                // zero limit returns every match
                want_reg  <= (count_limit == 5'd0) ? 5'd31 : count_limit;
            end else begin
                if (state_reg == S_LOAD)
                    nout_reg <= nout_reg + 1'b1;
                if (state_reg == S_D2 && op_q == vps_pkg::OP_KNN && first_reg && dist_in_rad)
                    match_reg <= match_reg + 1'b1;
                if (cmd.pass_clear)
                    first_reg <= 1'b0;
            end
            if (acc && !op_scan) begin
                ov_reg   <= 1'b1;
                last_reg <= 1'b1;
                pt_reg   <= 1'b0;
                if (opcode == vps_pkg::OP_INSERT)
                    st_reg <= sts.room ? vps_pkg::ST_INSERTED : vps_pkg::ST_DROPPED;
                else
                    st_reg <= vps_pkg::ST_NONE;
            end else if (state_reg == S_LOAD) begin
                ov_reg <= 1'b1;
                pt_reg <= 1'b1;
                st_reg <= vps_pkg::ST_POINT;
                if (op_q == vps_pkg::OP_NEAREST)
                    last_reg <= 1'b1;
                else if (op_q == vps_pkg::OP_READ)
                    last_reg <= sts.scan_end;
                else
                    last_reg <= knn_last;
            end else if (state_reg == S_OUT) begin
                ov_reg   <= 1'b1;
                last_reg <= 1'b1;
                pt_reg   <= 1'b0;
                st_reg   <= (op_q == vps_pkg::OP_PRUNE) ? vps_pkg::ST_PRUNED
                            : vps_pkg::ST_NONE;
            end else if (read_none) begin
                ov_reg   <= 1'b1;
                last_reg <= 1'b1;
                pt_reg   <= 1'b0;
                st_reg   <= vps_pkg::ST_NONE;
            end else if (ov_reg && out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end
endmodule

// File: hw/rtl/voxel_point_store_knn_unit.sv
`timescale 1ns / 1ps
// insert and unknown opcodes: one item accepted, result registered the next cycle
// read all: S_SCAN then S_LOAD for each stored point
// nearest and prune: S_SCAN, S_D1, S_D2 per stored point, then S_PICK
// k-nearest: a S_SCAN, S_D1, S_D2 pass over the store for each returned point
// one item in flight at a time; output stalls hold the scan
// rst_n asynchronously clears the fill count, controller and output valid
module voxel_point_store_knn_unit #(
    parameter int CAPACITY   = 16,
    parameter int COORD_BITS = 24
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [4:0] cfg_wdata,
    vps_in_if.sink   in_ch,
    vps_out_if.source out_ch
);
    logic [4:0] cap_reg;
    logic [2:0] op_reg;
    logic load_op;
    vps_pkg::vps_cmd_t cmd;
    vps_pkg::vps_sts_t sts;
    logic dist_in_rad, out_point, out_last;
    logic [2:0] out_status;
    logic signed [COORD_BITS-1:0] rx, ry, rz;
    logic [15:0] rtag;
    logic [4:0] fill;
    logic [2:0] dp_op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg <= '0;
            op_reg  <= vps_pkg::OP_INSERT;
        end else begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (load_op)
                op_reg <= in_ch.opcode;
        end
    end

    assign dp_op = load_op ? in_ch.opcode : op_reg;

    vps_datapath #(.CAPACITY(CAPACITY), .COORD_BITS(COORD_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .capacity_limit(cap_reg), .opcode(dp_op),
        .point_x(in_ch.point_x), .point_y(in_ch.point_y), .point_z(in_ch.point_z),
        .point_tag(in_ch.point_tag), .radius(in_ch.radius), .cmd(cmd), .sts(sts),
        .dist_in_rad(dist_in_rad), .res_x(rx), .res_y(ry), .res_z(rz),
        .res_tag(rtag), .fill_count(fill)
    );

    vps_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .opcode(in_ch.opcode), .count_limit(in_ch.count_limit), .op_q(op_reg),
        .dist_in_rad(dist_in_rad), .sts(sts), .cmd(cmd), .load_op(load_op),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_status(out_status),
        .out_point(out_point), .out_last(out_last)
    );

    assign out_ch.status       = out_status;
    assign out_ch.out_x        = out_point ? rx : '0;
    assign out_ch.out_y        = out_point ? ry : '0;
    assign out_ch.out_z        = out_point ? rz : '0;
    assign out_ch.out_tag      = out_point ? rtag : '0;
    assign out_ch.stored_count = fill;
    assign out_ch.last         = out_last;
endmodule

// File: hw/rtl/vps_checker.sv
`timescale 1ns / 1ps
module vps_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [2:0] status,
    input logic [4:0] stored_count,
    input logic last
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("output dropped while stalled");
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == vps_pkg::ST_NONE |-> last)
        else $error("none result not last");
    a_ins_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == vps_pkg::ST_INSERTED || status == vps_pkg::ST_PRUNED) |-> last)
        else $error("single result not last");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stored_count <= 5'd16)
        else $error("count out of range");
endmodule

bind voxel_point_store_knn_unit vps_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.status),
    .stored_count(out_ch.stored_count), .last(out_ch.last)
);
